// ===== sv/sida_pkg.sv =====
package sida_pkg;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Divide by ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for all 32-bit x
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;

    // Digit buffer
    localparam int MAX_DIGITS = 10;
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Classified number: sign and unsigned magnitude
    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } item_t;

endpackage

// ===== sv/sida_front.sv =====
module sida_front
    import sida_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    output logic        push_valid,
    input  logic        push_ready,
    output item_t       push_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    assign s_ready    = !valid_reg || push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    // Classify: split sign, negate to an unsigned magnitude
    always_comb begin
        item_next.neg = s_value[31];
        item_next.mag = s_value[31] ? (32'd0 - s_value) : s_value;
    end

    // Hold the classified beat until the queue takes it
    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/sida_queue.sv =====
module sida_queue
    import sida_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_CW-1:0]  count_reg;
    logic [QUEUE_CW-1:0]  count_next;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/sida_back.sv =====
module sida_back
    import sida_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  item_t      pop_item,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_character,
    output logic       m_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_DIG  = 2'd3;

    logic [1:0]           st_reg;
    logic [1:0]           st_next;
    logic [63:0]          prod_reg;
    logic [31:0]          prev_reg;
    logic                 neg_reg;
    logic [DIG_IDX_W-1:0] cnt_reg;
    logic [DIG_IDX_W-1:0] idx_reg;
    logic [DIG_IDX_W-1:0] idx_next;
    logic [3:0]           dig_reg [MAX_DIGITS];

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [7:0]           char_reg;
    logic [7:0]           char_next;
    logic                 last_reg;
    logic                 last_next;

    logic                 load;
    logic                 out_free;
    logic                 issue;
    logic [31:0]          mul_in;
    logic [63:0]          prod_calc;
    logic [QUOT_W-1:0]    quot;
    logic [31:0]          ten_quot;
    logic [31:0]          rem;

    assign pop_ready = (st_reg == ST_IDLE);
    assign load      = pop_valid && pop_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign issue     = out_free && (st_reg inside {ST_SIGN, ST_DIG});

    // Reciprocal multiply: start on the magnitude, then on each quotient
    assign quot      = prod_reg[63:RECIP_SHIFT];
    assign mul_in    = load ? pop_item.mag : 32'(quot);
    assign prod_calc = {32'd0, mul_in} * {32'd0, RECIP_TEN};

    // Remainder of the previous dividend is the next digit, LSB first
    assign ten_quot  = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem       = prev_reg - ten_quot;

    // Sequence: convert, then emit a minus sign if negative and the digits MSB first
    always_comb begin
        st_next   = st_reg;
        idx_next  = idx_reg;
        char_next = char_reg;
        last_next = last_reg;
        case (st_reg)
            ST_IDLE: begin
                if (load) begin
                    st_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (quot == '0) begin
                    idx_next = cnt_reg;
                    st_next  = neg_reg ? ST_SIGN : ST_DIG;
                end
            end
            ST_SIGN: begin
                if (issue) begin
                    char_next = CHAR_MINUS;
                    last_next = 1'b0;
                    st_next   = ST_DIG;
                end
            end
            ST_DIG: begin
                if (issue) begin
                    char_next = CHAR_ZERO + {4'd0, dig_reg[idx_reg]};
                    last_next = (idx_reg == '0);
                    if (idx_reg == '0) begin
                        st_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Output register: hold the beat until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (issue) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if (load) begin
            prod_reg <= prod_calc;
            prev_reg <= pop_item.mag;
            neg_reg  <= pop_item.neg;
            cnt_reg  <= '0;
        end else if (st_reg == ST_CONV) begin
            prod_reg         <= prod_calc;
            prev_reg         <= 32'(quot);
            dig_reg[cnt_reg] <= rem[3:0];
            if (quot != '0) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;

    // The digit counter never runs past the buffer while converting
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_CONV) |-> (cnt_reg < DIG_IDX_W'(MAX_DIGITS)))
        else $error("digit counter out of range");

    // Emission only reads digits that conversion wrote
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DIG) |-> (idx_reg <= cnt_reg))
        else $error("digit index beyond converted digits");

    // A number never ends on its sign
    a_last_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && last_reg) |-> (char_reg != CHAR_MINUS))
        else $error("last beat carries a minus sign");

    // A number taken from the queue always starts conversion next cycle
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (st_reg == ST_CONV))
        else $error("pop did not start conversion");

endmodule

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Channel  Ports                               Beat
// -------  ----------------------------------  -----------------------------------
// input    s_valid, s_ready, s_value[31:0]     one signed 32-bit number
// output   m_valid, m_ready, m_character[7:0]  one ASCII character, m_last on the
//          m_last                              final character of a number
//
// A number leaves the queue, passes once per digit through the
// reciprocal-multiply divide-by-ten loop, then goes out one character per
// cycle while the output is not stalled, a minus sign first if negative.
// The front register and a two-entry queue take further numbers meanwhile.
// aresetn is synchronous, active low; it empties the queue and the output.
// Output stalls hold the back end; input stalls only when the queue is full.
module signed_int_to_decimal_ascii
    import sida_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_character,
    output logic        m_last
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    sida_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    sida_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    sida_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule
